// ===== rtl/tlws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlws_pkg: shared types and constants for text line/word statistics
// Character codes, register indexes, reset values and the beat structures
// passed between the front end, the queues and the back end.
// ----------------------------------------------------------------------------
package tlws_pkg;

   localparam int COUNT_BITS_DEF  = 32;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAB_SIZE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHECK_WIDTH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIND_CHAR   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRINT_START = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRINT_EVERY = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPORT_ALL  = 3'd5;

   localparam logic [7:0]  TAB_SIZE_RST    = 8'd8;
   localparam logic [15:0] CHECK_WIDTH_RST = 16'd0;
   localparam logic [8:0]  FIND_CHAR_RST   = 9'h1FF;
   localparam logic [15:0] PRINT_START_RST = 16'd0;
   localparam logic [15:0] PRINT_EVERY_RST = 16'd1;
   localparam logic        REPORT_ALL_RST  = 1'b1;

   typedef struct packed {
      logic [7:0]        tab_size;
      logic [15:0]       check_width;
      logic signed [8:0] find_char;
      logic [15:0]       print_start;
      logic [15:0]       print_every;
      logic              report_all;
   } cfg_type;

   typedef struct packed {
      logic        tab_wr;
      logic        start_wr;
      logic [15:0] start_val;
   } csr_evt_type;

   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
      logic       line_end;
      logic       tab;
      logic       sep;
      logic       found;
   } fe_item_type;

   typedef struct packed {
      logic        echo;
      logic [7:0]  echo_byte;
      logic        char_found;
      logic        too_wide;
      logic [31:0] line_before;
      logic [15:0] line_width;
      logic        stopped;
      logic        totals_valid;
      logic [31:0] total_bytes;
      logic [31:0] total_lines;
      logic [15:0] widest_line;
      logic [31:0] total_words;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== rtl/tlws_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlws_fifo: small register queue
// Holds up to DEPTH beats; head beat is shown while empty is low.
// ----------------------------------------------------------------------------
module tlws_fifo
   import tlws_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = push && !full;
   assign do_rd   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tlws_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlws_front: input stage and byte classifier
// Registers each accepted beat with its character class and find match.
// ----------------------------------------------------------------------------
module tlws_front
   import tlws_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    push,
   output logic         full,
   input  wire logic    op,
   input  wire logic [7:0] data,
   output logic         q_push,
   output fe_item_type  q_item,
   input  wire logic    q_full
);

   logic        valid_ff, valid_in;
   fe_item_type item_ff, item_in;
   logic        accept;

   assign full   = valid_ff && q_full;
   assign accept = push && !full;
   assign q_push = valid_ff && !q_full;
   assign q_item = item_ff;

   always_comb begin
      item_in.is_end   = op;
      item_in.data     = data;
      item_in.line_end = (data == CHAR_NL) || (data == CHAR_FF);
      item_in.tab      = (data == CHAR_TAB);
      item_in.sep      = (data == CHAR_SPACE) || (data == CHAR_TAB) || (data == CHAR_NL);
      item_in.found    = !cfg.find_char[8] && (data == cfg.find_char[7:0]);

      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tlws_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlws_back: statistics engine
// Updates counts, column, tab phase and echo countdown for one beat per cycle
// with output room; stalls to recompute an unknown tab phase bit-serially.
// ----------------------------------------------------------------------------
module tlws_back
   import tlws_pkg::*;
#(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire csr_evt_type csr_evt,
   input  wire logic        in_valid,
   input  wire fe_item_type in_item,
   output logic             in_pop,
   input  wire logic        out_full,
   output logic             out_push,
   output rsp_item_type     out_item
);

   localparam int NCW   = COLUMN_BITS + 1;
   localparam int CMPW  = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;
   localparam int DIVCW = $clog2(COLUMN_BITS + 1);
   localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;
   localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

   typedef enum logic [1:0] {
      ST_RUN = 2'b01,
      ST_DIV = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]   bytes_ff, bytes_in;
   logic [COUNT_BITS-1:0]   lines_ff, lines_in;
   logic [COUNT_BITS-1:0]   words_ff, words_in;
   logic [COLUMN_BITS-1:0]  column_ff, column_in;
   logic [COLUMN_BITS-1:0]  max_col_ff, max_col_in;
   logic                    prev_sep_ff, prev_sep_in;
   logic [15:0]             countdown_ff, countdown_in;
   logic                    halted_ff, halted_in;
   logic [7:0]              phase_ff, phase_in;
   logic                    phase_ok_ff, phase_ok_in;
   logic [7:0]              rem_ff, rem_in;
   logic [COLUMN_BITS-1:0]  dvd_ff, dvd_in;
   logic [DIVCW-1:0]        dcnt_ff, dcnt_in;

   logic                    fire;
   logic                    report;
   logic                    tab_big;
   logic [COUNT_BITS-1:0]   bytes_inc, lines_inc, words_inc;
   logic [COLUMN_BITS-1:0]  column_inc;
   logic [NCW-1:0]          next_stop;
   logic [15:0]             countdown_dec;
   logic [8:0]              div_trial;
   logic                    div_ge;

   assign fire     = (state_ff == ST_RUN) && phase_ok_ff && in_valid && !out_full;
   assign in_pop   = fire;
   assign out_push = fire;
   assign tab_big  = (cfg.tab_size > 8'd1);

   assign bytes_inc  = (bytes_ff == CNT_MAX) ? bytes_ff : bytes_ff + 1'b1;
   assign lines_inc  = (lines_ff == CNT_MAX) ? lines_ff : lines_ff + 1'b1;
   assign words_inc  = (words_ff == CNT_MAX) ? words_ff : words_ff + 1'b1;
   assign column_inc = (column_ff == COL_MAX) ? column_ff : column_ff + 1'b1;
   assign next_stop  = NCW'(column_ff) + NCW'(cfg.tab_size) - NCW'(phase_ff);
   assign countdown_dec = countdown_ff - 16'd1;

   assign div_trial = {rem_ff, dvd_ff[COLUMN_BITS-1]};
   assign div_ge    = (div_trial >= {1'b0, cfg.tab_size});

   always_comb begin
      state_in     = state_ff;
      bytes_in     = bytes_ff;
      lines_in     = lines_ff;
      words_in     = words_ff;
      column_in    = column_ff;
      max_col_in   = max_col_ff;
      prev_sep_in  = prev_sep_ff;
      countdown_in = countdown_ff;
      halted_in    = halted_ff;
      phase_in     = phase_ff;
      phase_ok_in  = phase_ok_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      dcnt_in      = dcnt_ff;
      out_item     = '0;
      report       = 1'b0;

      unique case (state_ff)
         ST_RUN: begin
            if (!phase_ok_ff) begin
               state_in = ST_DIV;
               rem_in   = '0;
               dvd_in   = column_ff;
               dcnt_in  = DIVCW'(COLUMN_BITS);
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? 8'(div_trial - {1'b0, cfg.tab_size}) : div_trial[7:0];
            dvd_in  = dvd_ff << 1;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == DIVCW'(1)) begin
               state_in    = ST_RUN;
               phase_in    = tab_big ? rem_in : 8'd0;
               phase_ok_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (fire) begin
         out_item.line_before = 32'(lines_ff);
         if (in_item.is_end) begin
            out_item.totals_valid = cfg.report_all;
            if (cfg.report_all) begin
               out_item.total_bytes = 32'(bytes_ff);
               out_item.total_lines = 32'(lines_ff);
               out_item.widest_line = 16'(max_col_ff);
               out_item.total_words = 32'(words_ff);
            end
            bytes_in     = '0;
            lines_in     = '0;
            words_in     = '0;
            column_in    = '0;
            max_col_in   = '0;
            prev_sep_in  = 1'b0;
            halted_in    = 1'b0;
            countdown_in = cfg.print_start;
            phase_in     = '0;
            phase_ok_in  = 1'b1;
         end else if (halted_ff) begin
            out_item.echo_byte = in_item.data;
            out_item.stopped   = 1'b1;
         end else begin
            out_item.echo       = (countdown_ff == 16'd1);
            out_item.echo_byte  = in_item.data;
            out_item.char_found = in_item.found;
            report              = in_item.found;
            if (in_item.line_end) begin
               lines_in = lines_inc;
               words_in = words_inc;
               if (column_ff > max_col_ff) begin
                  max_col_in = column_ff;
               end
               out_item.line_width = 16'(column_ff);
               if ((cfg.check_width != 16'd0) &&
                   (CMPW'(column_ff) > CMPW'(cfg.check_width))) begin
                  out_item.too_wide = 1'b1;
                  report            = 1'b1;
               end
               column_in = '0;
               phase_in  = '0;
               if (countdown_ff != 16'd0) begin
                  countdown_in = (countdown_dec == 16'd0) ? cfg.print_every : countdown_dec;
               end
            end else begin
               if (in_item.sep && !prev_sep_ff) begin
                  words_in = words_inc;
               end
               if (in_item.tab && tab_big) begin
                  if (next_stop[COLUMN_BITS]) begin
                     column_in   = COL_MAX;
                     phase_ok_in = 1'b0;
                  end else begin
                     column_in = next_stop[COLUMN_BITS-1:0];
                     phase_in  = '0;
                  end
               end else begin
                  column_in = column_inc;
                  if (!tab_big) begin
                     phase_in = '0;
                  end else if (column_ff != COL_MAX) begin
                     phase_in = (phase_ff == cfg.tab_size - 8'd1) ? 8'd0 : phase_ff + 8'd1;
                  end
               end
            end
            prev_sep_in = in_item.sep;
            bytes_in    = bytes_inc;
            if (report && !cfg.report_all) begin
               halted_in = 1'b1;
            end
         end
      end

      if (csr_evt.start_wr) begin
         countdown_in = csr_evt.start_val;
      end
      if (csr_evt.tab_wr) begin
         state_in    = ST_RUN;
         phase_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         bytes_ff     <= '0;
         lines_ff     <= '0;
         words_ff     <= '0;
         column_ff    <= '0;
         max_col_ff   <= '0;
         prev_sep_ff  <= 1'b0;
         countdown_ff <= PRINT_START_RST;
         halted_ff    <= 1'b0;
         phase_ff     <= '0;
         phase_ok_ff  <= 1'b1;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         bytes_ff     <= bytes_in;
         lines_ff     <= lines_in;
         words_ff     <= words_in;
         column_ff    <= column_in;
         max_col_ff   <= max_col_in;
         prev_sep_ff  <= prev_sep_in;
         countdown_ff <= countdown_in;
         halted_ff    <= halted_in;
         phase_ff     <= phase_in;
         phase_ok_ff  <= phase_ok_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

endmodule
`default_nettype wire

// ===== rtl/text_line_word_statistics.sv =====
`default_nettype none
// A result passes the front-end register, the middle queue and the output queue
// to the rsp ports. The back end's single state update takes one beat per cycle
// while the output queue has room and no recompute runs; a tab_size write, or a
// tab saturating the column, stalls it once for the bit-serial phase recompute.
// Reset (synchronous) clears counts and queues and loads the register defaults.
// ----------------------------------------------------------------------------
// text_line_word_statistics: byte, line and word statistics over a text stream
// Front end classifies beats, a short queue decouples it from the statistics
// engine, and an output queue holds results until popped.
// ----------------------------------------------------------------------------
module text_line_word_statistics
   import tlws_pkg::*;
#(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire logic                      req_op,
   input  wire logic [7:0]                req_data,
   output logic                           empty,
   input  wire logic                      pop,
   output logic                           rsp_echo,
   output logic [7:0]                     rsp_echo_byte,
   output logic                           rsp_char_found,
   output logic                           rsp_too_wide,
   output logic [31:0]                    rsp_line_before,
   output logic [15:0]                    rsp_line_width,
   output logic                           rsp_stopped,
   output logic                           rsp_totals_valid,
   output logic [31:0]                    rsp_total_bytes,
   output logic [31:0]                    rsp_total_lines,
   output logic [15:0]                    rsp_widest_line,
   output logic [31:0]                    rsp_total_words,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int FE_W  = $bits(fe_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   cfg_type      cfg_ff, cfg_in;
   csr_evt_type  csr_evt;
   logic         mid_push, mid_full, mid_empty, mid_pop;
   fe_item_type  mid_wr_item, mid_rd_item;
   logic [FE_W-1:0]  mid_rd_data;
   logic         out_push, out_full;
   rsp_item_type out_wr_item, rsp_q;
   logic [RSP_W-1:0] out_rd_data;

   always_comb begin
      cfg_in            = cfg_ff;
      csr_evt.tab_wr    = 1'b0;
      csr_evt.start_wr  = 1'b0;
      csr_evt.start_val = csr_wdata[15:0];
      if (csr_we) begin
         unique case (csr_index)
            CSR_TAB_SIZE: begin
               cfg_in.tab_size = csr_wdata[7:0];
               csr_evt.tab_wr  = 1'b1;
            end
            CSR_CHECK_WIDTH: cfg_in.check_width = csr_wdata[15:0];
            CSR_FIND_CHAR:   cfg_in.find_char   = csr_wdata[8:0];
            CSR_PRINT_START: begin
               cfg_in.print_start = csr_wdata[15:0];
               csr_evt.start_wr   = 1'b1;
            end
            CSR_PRINT_EVERY: cfg_in.print_every = csr_wdata[15:0];
            CSR_REPORT_ALL:  cfg_in.report_all  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tab_size    <= TAB_SIZE_RST;
         cfg_ff.check_width <= CHECK_WIDTH_RST;
         cfg_ff.find_char   <= FIND_CHAR_RST;
         cfg_ff.print_start <= PRINT_START_RST;
         cfg_ff.print_every <= PRINT_EVERY_RST;
         cfg_ff.report_all  <= REPORT_ALL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tlws_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .push   (push),
      .full   (full),
      .op     (req_op),
      .data   (req_data),
      .q_push (mid_push),
      .q_item (mid_wr_item),
      .q_full (mid_full)
   );

   tlws_fifo #(
      .WIDTH (FE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_wr_item),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd_data),
      .empty   (mid_empty)
   );

   assign mid_rd_item = fe_item_type'(mid_rd_data);

   tlws_back #(
      .COUNT_BITS  (COUNT_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .csr_evt  (csr_evt),
      .in_valid (!mid_empty),
      .in_item  (mid_rd_item),
      .in_pop   (mid_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (out_wr_item)
   );

   tlws_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr_item),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rd_data),
      .empty   (empty)
   );

   assign rsp_q            = rsp_item_type'(out_rd_data);
   assign rsp_echo         = rsp_q.echo;
   assign rsp_echo_byte    = rsp_q.echo_byte;
   assign rsp_char_found   = rsp_q.char_found;
   assign rsp_too_wide     = rsp_q.too_wide;
   assign rsp_line_before  = rsp_q.line_before;
   assign rsp_line_width   = rsp_q.line_width;
   assign rsp_stopped      = rsp_q.stopped;
   assign rsp_totals_valid = rsp_q.totals_valid;
   assign rsp_total_bytes  = rsp_q.total_bytes;
   assign rsp_total_lines  = rsp_q.total_lines;
   assign rsp_widest_line  = rsp_q.widest_line;
   assign rsp_total_words  = rsp_q.total_words;

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> !mid_full)
      else $error("front pushed into a full queue");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (!out_full && !mid_empty))
      else $error("back end fired without input or output room");

   a_stop_vs_totals: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_stopped && rsp_totals_valid))
      else $error("result marks both stopped and totals");

endmodule
`default_nettype wire
